/* hdl/convex_polygon_overlap_test_assert.svh */
// ----------------------------------------------------------------------------
// Convex polygon overlap test: assertion macros
// Shorthand for clocked implications used by the port checker.
// ----------------------------------------------------------------------------
`ifndef CONVEX_POLYGON_OVERLAP_TEST_ASSERT_SVH
`define CONVEX_POLYGON_OVERLAP_TEST_ASSERT_SVH

// Same-cycle implication, off during reset.
`define CPOT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define CPOT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/cpot_pkg.sv */
// ----------------------------------------------------------------------------
// cpot_pkg
// Shared constants and types of the convex polygon overlap test.
// ----------------------------------------------------------------------------
`default_nettype none

package cpot_pkg;

  // Width of the coordinate ports.
  localparam int FIELD_BITS = 16;

  // Smallest polygon the test accepts.
  localparam int MIN_VERTICES = 3;

  // Control from the sequencer to the projection unit.
  typedef struct packed {
    logic clear;  // start of a new axis: forget both ranges
    logic valid;  // vertex data on the read port is a projection operand
    logic poly;   // polygon the vertex belongs to
  } proj_ctl_t;

endpackage

`default_nettype wire

/* hdl/cpot_proj.sv */
// ----------------------------------------------------------------------------
// cpot_proj
// Projects vertices onto the current axis and tracks each polygon's range.
// ----------------------------------------------------------------------------
`default_nettype none

module cpot_proj #(
  parameter int COORD_BITS = 16
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire cpot_pkg::proj_ctl_t    ctl_i,
  input  wire signed [COORD_BITS-1:0] vx_i,
  input  wire signed [COORD_BITS-1:0] vy_i,
  input  wire signed [COORD_BITS:0]   nx_i,
  input  wire signed [COORD_BITS:0]   ny_i,
  output logic                        sep_o,
  output logic                        pend_o
);

  localparam int PW = 2 * COORD_BITS + 1;
  localparam int DW = PW + 1;

  logic signed [PW-1:0] px_q, py_q;
  logic                 v_q, tag_q;
  logic [1:0]           seen_q;
  logic signed [DW-1:0] lo0_q, hi0_q, lo1_q, hi1_q;
  logic signed [DW-1:0] dot;

  // Products registered before the sum.
  always_ff @(posedge clk_i) begin
    px_q <= PW'(vx_i) * PW'(nx_i);
    py_q <= PW'(vy_i) * PW'(ny_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= 1'b0;
      tag_q  <= 1'b0;
      seen_q <= '0;
    end else begin
      v_q   <= ctl_i.valid;
      tag_q <= ctl_i.poly;
      if (ctl_i.clear) begin
        seen_q <= '0;
      end else if (v_q) begin
        seen_q[tag_q] <= 1'b1;
      end
    end
  end

  assign dot = DW'(px_q) + DW'(py_q);

  // Min/max update; first projection of an axis seeds both ends.
  always_ff @(posedge clk_i) begin
    if (v_q && !tag_q) begin
      if (!seen_q[0] || dot < lo0_q) lo0_q <= dot;
      if (!seen_q[0] || dot > hi0_q) hi0_q <= dot;
    end
    if (v_q && tag_q) begin
      if (!seen_q[1] || dot < lo1_q) lo1_q <= dot;
      if (!seen_q[1] || dot > hi1_q) hi1_q <= dot;
    end
  end

  // Touching ranges do not separate.
  assign sep_o  = (hi0_q < lo1_q) || (hi1_q < lo0_q);
  assign pend_o = v_q;

endmodule

`default_nettype wire

/* hdl/convex_polygon_overlap_test.sv */
// ----------------------------------------------------------------------------
// convex_polygon_overlap_test
// Separating-axis overlap test of two convex polygons held in a vertex memory.
// ----------------------------------------------------------------------------
// Usage:
//   Transfer one vertex per cycle while busy_o is low: a vertex is taken at a
//   rising edge with start_i high and busy_o low. polygon_id_i picks the
//   polygon, vertex_x_i/vertex_y_i give the point. Vertices beyond
//   MAX_VERTICES per polygon are dropped and flag the next test as bad.
//   The vertex with last_vertex_i high is stored and starts the test; busy_o
//   then stays high until the result. Vertices without the mark give no
//   result.
//   The result is shown for one cycle with done_o high: overlap_o (touching
//   counts as overlap) and bad_input_o (a polygon under 3 vertices, or a
//   dropped vertex). The receiver cannot stall; done_o is a pulse.
//   On bad input the result follows the vertex count check; otherwise the
//   test walks the axes and ends early when an axis separates. Each axis
//   costs two reads for its edge, one read per vertex for projection, and a
//   drain of the multiply pipeline; the single read port of the vertex
//   memory sets this pace.
//   Reset clears the vertex counts and the overflow flag; memory contents
//   are left as they are. After each result the counts clear again.
// ----------------------------------------------------------------------------
`default_nettype none

module convex_polygon_overlap_test #(
  parameter int MAX_VERTICES = 8,
  parameter int COORD_BITS   = 16
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  start_i,
  output logic                                 busy_o,
  input  wire                                  polygon_id_i,
  input  wire signed [cpot_pkg::FIELD_BITS-1:0] vertex_x_i,
  input  wire signed [cpot_pkg::FIELD_BITS-1:0] vertex_y_i,
  input  wire                                  last_vertex_i,
  output logic                                 done_o,
  output logic                                 overlap_o,
  output logic                                 bad_input_o
);

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int AW = IW + 1;
  localparam int NW = COORD_BITS + 1;
  localparam int MW = 2 * COORD_BITS;

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;  // load vertices
  localparam logic [2:0] S_CHECK = 3'd1;  // vertex count check
  localparam logic [2:0] S_EDGE0 = 3'd2;  // read edge start
  localparam logic [2:0] S_EDGE1 = 3'd3;  // read edge end
  localparam logic [2:0] S_NORM  = 3'd4;  // form the normal
  localparam logic [2:0] S_PROJ  = 3'd5;  // read every vertex for projection
  localparam logic [2:0] S_DRAIN = 3'd6;  // let the multiply pipeline empty
  localparam logic [2:0] S_CMP   = 3'd7;  // compare the two ranges

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt0_q, cnt0_d, cnt1_q, cnt1_d;
  logic          ovf_q, ovf_d;
  logic          ap_q, ap_d;          // polygon that owns the axis edge
  logic [IW-1:0] ai_q, ai_d;          // edge index
  logic          pp_q, pp_d;          // polygon being projected
  logic [IW-1:0] pk_q, pk_d;          // vertex being projected
  logic          rd_v_q, rd_tag_q;
  logic          done_q, done_d;
  logic          overlap_q, overlap_d, bad_q, bad_d;

  logic signed [COORD_BITS-1:0] vix_q, vix_d, viy_q, viy_d;
  logic signed [NW-1:0]         nx_q, nx_d, ny_q, ny_d;

  // Vertex memory: entry {polygon, index} holds {x, y}.
  logic [MW-1:0] mem [2**AW];
  logic [MW-1:0] rdata_q;
  logic [AW-1:0] raddr, waddr;
  logic          we;

  logic                         accept;
  logic [CW-1:0]                cnt_sel;
  logic [COORD_BITS-1:0]        cx, cy;
  logic signed [COORD_BITS-1:0] rx, ry;
  logic [CW-1:0]                ai_inc, ap_n, pk_inc, pp_n;
  logic                         ai_wrap, pk_wrap;
  logic [IW-1:0]                aj;
  logic                         sep, pend, bad_now;
  cpot_pkg::proj_ctl_t          proj_ctl;

  // Coordinates: the low COORD_BITS of the zero-extended field.
  assign cx = COORD_BITS'({{COORD_BITS{1'b0}}, vertex_x_i});
  assign cy = COORD_BITS'({{COORD_BITS{1'b0}}, vertex_y_i});

  assign accept  = start_i && (state_q == S_IDLE);
  assign cnt_sel = polygon_id_i ? cnt1_q : cnt0_q;
  assign we      = accept && (cnt_sel < CW'(MAX_VERTICES));
  assign waddr   = {polygon_id_i, cnt_sel[IW-1:0]};

  assign rx = $signed(rdata_q[MW-1:COORD_BITS]);
  assign ry = $signed(rdata_q[COORD_BITS-1:0]);

  // Next edge vertex, wrapping to close the polygon.
  assign ap_n    = ap_q ? cnt1_q : cnt0_q;
  assign ai_inc  = CW'(ai_q) + CW'(1);
  assign ai_wrap = (ai_inc == ap_n);
  assign aj      = ai_wrap ? '0 : ai_inc[IW-1:0];

  assign pp_n    = pp_q ? cnt1_q : cnt0_q;
  assign pk_inc  = CW'(pk_q) + CW'(1);
  assign pk_wrap = (pk_inc == pp_n);

  assign bad_now = ovf_q || (cnt0_q < CW'(cpot_pkg::MIN_VERTICES))
                         || (cnt1_q < CW'(cpot_pkg::MIN_VERTICES));

  always_comb begin
    case (state_q)
      S_EDGE0: raddr = {ap_q, ai_q};
      S_EDGE1: raddr = {ap_q, aj};
      default: raddr = {pp_q, pk_q};
    endcase
  end

  // Writes happen only while idle; the test reads only while busy.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= {cx, cy};
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    state_d   = state_q;
    cnt0_d    = cnt0_q;
    cnt1_d    = cnt1_q;
    ovf_d     = ovf_q;
    ap_d      = ap_q;
    ai_d      = ai_q;
    pp_d      = pp_q;
    pk_d      = pk_q;
    done_d    = 1'b0;
    overlap_d = overlap_q;
    bad_d     = bad_q;
    vix_d     = vix_q;
    viy_d     = viy_q;
    nx_d      = nx_q;
    ny_d      = ny_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (we) begin
            if (polygon_id_i) cnt1_d = cnt1_q + CW'(1);
            else              cnt0_d = cnt0_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_vertex_i) state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (bad_now) begin
          done_d    = 1'b1;
          overlap_d = 1'b0;
          bad_d     = 1'b1;
          state_d   = S_IDLE;
        end else begin
          ap_d    = 1'b0;
          ai_d    = '0;
          state_d = S_EDGE0;
        end
      end
      S_EDGE0: state_d = S_EDGE1;
      S_EDGE1: begin
        // Edge start arrives from the read issued in S_EDGE0.
        vix_d   = rx;
        viy_d   = ry;
        state_d = S_NORM;
      end
      S_NORM: begin
        // Normal (-dy, dx) of the edge.
        nx_d    = NW'(viy_q) - NW'(ry);
        ny_d    = NW'(rx) - NW'(vix_q);
        pp_d    = 1'b0;
        pk_d    = '0;
        state_d = S_PROJ;
      end
      S_PROJ: begin
        if (pk_wrap) begin
          pk_d = '0;
          if (pp_q) state_d = S_DRAIN;
          else      pp_d    = 1'b1;
        end else begin
          pk_d = pk_inc[IW-1:0];
        end
      end
      S_DRAIN: begin
        if (!rd_v_q && !pend) state_d = S_CMP;
      end
      S_CMP: begin
        if (sep) begin
          done_d    = 1'b1;
          overlap_d = 1'b0;
          bad_d     = 1'b0;
          state_d   = S_IDLE;
        end else if (ai_wrap && ap_q) begin
          done_d    = 1'b1;
          overlap_d = 1'b1;
          bad_d     = 1'b0;
          state_d   = S_IDLE;
        end else if (ai_wrap) begin
          ap_d    = 1'b1;
          ai_d    = '0;
          state_d = S_EDGE0;
        end else begin
          ai_d    = aj;
          state_d = S_EDGE0;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Clear the stores' bookkeeping after every result.
    if (done_d) begin
      cnt0_d = '0;
      cnt1_d = '0;
      ovf_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt0_q   <= '0;
      cnt1_q   <= '0;
      ovf_q    <= 1'b0;
      ap_q     <= 1'b0;
      ai_q     <= '0;
      pp_q     <= 1'b0;
      pk_q     <= '0;
      rd_v_q   <= 1'b0;
      rd_tag_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt0_q   <= cnt0_d;
      cnt1_q   <= cnt1_d;
      ovf_q    <= ovf_d;
      ap_q     <= ap_d;
      ai_q     <= ai_d;
      pp_q     <= pp_d;
      pk_q     <= pk_d;
      rd_v_q   <= (state_q == S_PROJ);
      rd_tag_q <= pp_q;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    overlap_q <= overlap_d;
    bad_q     <= bad_d;
    vix_q     <= vix_d;
    viy_q     <= viy_d;
    nx_q      <= nx_d;
    ny_q      <= ny_d;
  end

  assign proj_ctl.clear = (state_q == S_NORM);
  assign proj_ctl.valid = rd_v_q;
  assign proj_ctl.poly  = rd_tag_q;

  cpot_proj #(
    .COORD_BITS(COORD_BITS)
  ) u_proj (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (proj_ctl),
    .vx_i   (rx),
    .vy_i   (ry),
    .nx_i   (nx_q),
    .ny_i   (ny_q),
    .sep_o  (sep),
    .pend_o (pend)
  );

  assign busy_o      = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign overlap_o   = overlap_q;
  assign bad_input_o = bad_q;

endmodule

`default_nettype wire

/* hdl/cpot_checker.sv */
// ----------------------------------------------------------------------------
// cpot_checker
// Port-level checks of the overlap test, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "convex_polygon_overlap_test_assert.svh"

module cpot_checker (
  input wire clk_i,
  input wire rst_ni,
  input wire start_i,
  input wire busy_o,
  input wire last_vertex_i,
  input wire done_o,
  input wire overlap_o,
  input wire bad_input_o
);

  `CPOT_ASSERT_NOW(a_done_idle, clk_i, rst_ni, done_o, !busy_o, "result while busy")
  `CPOT_ASSERT_NOW(a_bad_no_overlap, clk_i, rst_ni, done_o && bad_input_o, !overlap_o, "bad input reports overlap")
  `CPOT_ASSERT_NEXT(a_plain_vertex, clk_i, rst_ni, start_i && !busy_o && !last_vertex_i, !busy_o, "test started without last vertex")
  `CPOT_ASSERT_NOW(a_fall_done, clk_i, rst_ni, $fell(busy_o), done_o, "test ended without result")

endmodule

bind convex_polygon_overlap_test cpot_checker u_cpot_checker (.*);

`default_nettype wire
